>>> rtl/vmies_pkg.sv
// Package with shared types and constants of the instruction execute block.
`default_nettype none

package vmies_pkg;

   localparam int ADDR_W = 12;
   localparam int DATA_W = 8;
   localparam int INS_W = 16;
   localparam int REG_COUNT = 16;
   localparam int REG_IDX_W = 4;
   localparam int STACK_DEPTH_DEF = 16;

   localparam logic [ADDR_W-1:0] PC_RESET = 12'h200;
   localparam logic [INS_W-1:0] INS_RET = 16'h00EE;
   localparam logic [ADDR_W-1:0] PC_STEP = 12'h002;
   localparam logic [ADDR_W-1:0] PC_SKIP_STEP = 12'h004;

   typedef enum logic [3:0] {
      OP_SYS  = 4'h0,
      OP_JP   = 4'h1,
      OP_CALL = 4'h2,
      OP_SE   = 4'h3,
      OP_SNE  = 4'h4,
      OP_SER  = 4'h5,
      OP_LD   = 4'h6,
      OP_ADD  = 4'h7,
      OP_ALU  = 4'h8,
      OP_SNER = 4'h9,
      OP_LDI  = 4'hA,
      OP_JPV0 = 4'hB,
      OP_RND  = 4'hC,
      OP_DRW  = 4'hD,
      OP_KEY  = 4'hE,
      OP_MISC = 4'hF
   } op_type;

   typedef struct packed {
      logic [ADDR_W-1:0]    next_pc;
      logic                 write_valid;
      logic [REG_IDX_W-1:0] write_index;
      logic [DATA_W-1:0]    write_value;
      logic [ADDR_W-1:0]    index_value;
      logic                 skipped;
      logic                 unhandled;
   } rsp_type;

   typedef struct packed {
      logic push;
      logic pop;
   } stack_ctl_type;

endpackage

`default_nettype wire

>>> rtl/vmies_if.sv
// Request and response channel interfaces of the instruction execute block.
`default_nettype none

interface vmies_req_if;
   logic                         valid;
   logic                         ready;
   logic [vmies_pkg::INS_W-1:0]  instruction;

   modport source (output valid, output instruction, input ready);
   modport sink (input valid, input instruction, output ready);
endinterface

interface vmies_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [vmies_pkg::ADDR_W-1:0]     next_pc;
   logic                             write_valid;
   logic [vmies_pkg::REG_IDX_W-1:0]  write_index;
   logic [vmies_pkg::DATA_W-1:0]     write_value;
   logic [vmies_pkg::ADDR_W-1:0]     index_value;
   logic                             skipped;
   logic                             unhandled;

   modport source (output valid, output next_pc, output write_valid, output write_index,
                   output write_value, output index_value, output skipped,
                   output unhandled, input ready);
   modport sink (input valid, input next_pc, input write_valid, input write_index,
                 input write_value, input index_value, input skipped,
                 input unhandled, output ready);
endinterface

`default_nettype wire

>>> rtl/vmies_exec.sv
// Instruction decode and execute logic for one instruction.
`default_nettype none

module vmies_exec (
   input  wire logic [vmies_pkg::INS_W-1:0]   instruction,
   input  wire logic [vmies_pkg::ADDR_W-1:0]  pc,
   input  wire logic [vmies_pkg::ADDR_W-1:0]  index_reg,
   input  wire logic [vmies_pkg::ADDR_W-1:0]  stack_top,
   input  wire logic [vmies_pkg::DATA_W-1:0]  vx,
   input  wire logic [vmies_pkg::DATA_W-1:0]  vy,
   input  wire logic [vmies_pkg::DATA_W-1:0]  v0,
   output vmies_pkg::rsp_type                 result,
   output vmies_pkg::stack_ctl_type           stack_ctl
);

   logic [vmies_pkg::ADDR_W-1:0]     nnn;
   logic [vmies_pkg::DATA_W-1:0]     kk;
   logic [vmies_pkg::REG_IDX_W-1:0]  x_idx;
   logic [vmies_pkg::ADDR_W-1:0]     pc_plus2;
   logic [vmies_pkg::ADDR_W-1:0]     pc_plus4;
   logic                             skip;

   assign nnn = instruction[vmies_pkg::ADDR_W-1:0];
   assign kk = instruction[vmies_pkg::DATA_W-1:0];
   assign x_idx = instruction[11:8];
   assign pc_plus2 = pc + vmies_pkg::PC_STEP;
   assign pc_plus4 = pc + vmies_pkg::PC_SKIP_STEP;

   always_comb begin
      skip = 1'b0;
      result.next_pc = pc_plus2;
      result.write_valid = 1'b0;
      result.write_index = '0;
      result.write_value = '0;
      result.index_value = index_reg;
      result.unhandled = 1'b0;
      stack_ctl.push = 1'b0;
      stack_ctl.pop = 1'b0;
      unique case (vmies_pkg::op_type'(instruction[15:12]))
         vmies_pkg::OP_SYS: begin
            if (instruction == vmies_pkg::INS_RET) begin
               stack_ctl.pop = 1'b1;
               result.next_pc = stack_top;
            end else begin
               result.unhandled = 1'b1;
            end
         end
         vmies_pkg::OP_JP: begin
            result.next_pc = nnn;
         end
         vmies_pkg::OP_CALL: begin
            stack_ctl.push = 1'b1;
            result.next_pc = nnn;
         end
         vmies_pkg::OP_SE: begin
            skip = (vx == kk);
         end
         vmies_pkg::OP_SNE: begin
            skip = (vx != kk);
         end
         vmies_pkg::OP_SER: begin
            if (instruction[3:0] == 4'h0) begin
               skip = (vx == vy);
            end else begin
               result.unhandled = 1'b1;
            end
         end
         vmies_pkg::OP_LD: begin
            result.write_valid = 1'b1;
            result.write_index = x_idx;
            result.write_value = kk;
         end
         vmies_pkg::OP_ADD: begin
            result.write_valid = 1'b1;
            result.write_index = x_idx;
            result.write_value = vx + kk;
         end
         vmies_pkg::OP_LDI: begin
            result.index_value = nnn;
         end
         vmies_pkg::OP_JPV0: begin
            result.next_pc = nnn + {{(vmies_pkg::ADDR_W-vmies_pkg::DATA_W){1'b0}}, v0};
         end
         default: begin
            result.unhandled = 1'b1;
         end
      endcase
      if (skip) begin
         result.next_pc = pc_plus4;
      end
      result.skipped = skip;
   end

endmodule

`default_nettype wire

>>> rtl/vmies_stack.sv
// Return address stack with cached top and second entries.
`default_nettype none

module vmies_stack #(
   parameter int STACK_DEPTH = vmies_pkg::STACK_DEPTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire logic                          pop,
   input  wire logic [vmies_pkg::ADDR_W-1:0]  push_value,
   output logic [vmies_pkg::ADDR_W-1:0]       stack_top
);

   localparam int SpW = $clog2(STACK_DEPTH);
   localparam int RdReset = (3 * STACK_DEPTH - 3) % STACK_DEPTH;
   localparam logic [SpW-1:0] LastPtr = SpW'(STACK_DEPTH - 1);

   logic [vmies_pkg::ADDR_W-1:0] mem [STACK_DEPTH];
   logic [SpW-1:0]               sp_ff;
   logic [SpW-1:0]               sp_in;
   logic [SpW-1:0]               rd_ptr_ff;
   logic [SpW-1:0]               rd_ptr_in;
   logic [vmies_pkg::ADDR_W-1:0] top_ff;
   logic [vmies_pkg::ADDR_W-1:0] second_ff;

   function automatic logic [SpW-1:0] ptr_inc(input logic [SpW-1:0] p);
      return (p == LastPtr) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [SpW-1:0] ptr_dec(input logic [SpW-1:0] p);
      return (p == '0) ? LastPtr : p - 1'b1;
   endfunction

   // The cached entries hold the stack at one and two below the stack pointer,
   // and the read pointer runs three below it to refill the second entry on a pop.
   always_comb begin
      sp_in = sp_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         sp_in = ptr_inc(sp_ff);
         rd_ptr_in = ptr_inc(rd_ptr_ff);
      end else if (pop) begin
         sp_in = ptr_dec(sp_ff);
         rd_ptr_in = ptr_dec(rd_ptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sp_ff <= '0;
         rd_ptr_ff <= SpW'(RdReset);
      end else begin
         sp_ff <= sp_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[sp_ff] <= push_value;
         top_ff <= push_value;
         second_ff <= top_ff;
      end else if (pop) begin
         top_ff <= second_ff;
         second_ff <= mem[rd_ptr_ff];
      end
   end

   assign stack_top = top_ff;

endmodule

`default_nettype wire

>>> rtl/vm_instruction_execute_subset.sv
// Top level of the instruction execute block for the virtual machine subset.
`default_nettype none

// Executes one instruction per clock cycle when neither side stalls. A request is
// taken into an input register, where its data register operands are read with
// forwarding from the instruction ahead of it; once the output register is free it
// executes against the program counter, index register and return stack, and its
// response lands in the output register, from which it is presented. The update of
// the program counter and registers as each instruction executes sets the rate.
// After reset the block is ready at once; unsupported instructions are reported as
// unhandled and only advance the program counter.
module vm_instruction_execute_subset #(
   parameter int STACK_DEPTH = vmies_pkg::STACK_DEPTH_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   vmies_req_if.sink         req_bus,
   vmies_rsp_if.source       rsp_bus
);

   logic [vmies_pkg::DATA_W-1:0]     dreg_ff [vmies_pkg::REG_COUNT];
   logic                             s1_valid_ff;
   logic [vmies_pkg::INS_W-1:0]      s1_ins_ff;
   logic [vmies_pkg::DATA_W-1:0]     vx_ff;
   logic [vmies_pkg::DATA_W-1:0]     vy_ff;
   logic [vmies_pkg::DATA_W-1:0]     v0_ff;
   logic [vmies_pkg::DATA_W-1:0]     vx_in;
   logic [vmies_pkg::DATA_W-1:0]     vy_in;
   logic [vmies_pkg::DATA_W-1:0]     v0_in;
   logic [vmies_pkg::ADDR_W-1:0]     pc_ff;
   logic [vmies_pkg::ADDR_W-1:0]     index_ff;
   logic                             rsp_valid_ff;
   vmies_pkg::rsp_type               rsp_ff;
   vmies_pkg::rsp_type               exec_result;
   vmies_pkg::stack_ctl_type         exec_stack_ctl;
   logic [vmies_pkg::ADDR_W-1:0]     stack_top;
   logic                             out_ready;
   logic                             exec_go;
   logic                             req_go;
   logic                             fwd_write;
   logic [vmies_pkg::REG_IDX_W-1:0]  rd_x;
   logic [vmies_pkg::REG_IDX_W-1:0]  rd_y;

   assign out_ready = !rsp_valid_ff || rsp_bus.ready;
   assign exec_go = s1_valid_ff && out_ready;
   assign req_bus.ready = !s1_valid_ff || out_ready;
   assign req_go = req_bus.valid && req_bus.ready;

   assign rd_x = req_bus.instruction[11:8];
   assign rd_y = req_bus.instruction[7:4];
   assign fwd_write = exec_go && exec_result.write_valid;

   always_comb begin
      vx_in = dreg_ff[rd_x];
      vy_in = dreg_ff[rd_y];
      v0_in = dreg_ff[0];
      if (fwd_write && exec_result.write_index == rd_x) begin
         vx_in = exec_result.write_value;
      end
      if (fwd_write && exec_result.write_index == rd_y) begin
         vy_in = exec_result.write_value;
      end
      if (fwd_write && exec_result.write_index == '0) begin
         v0_in = exec_result.write_value;
      end
   end

   vmies_exec u_exec (
      .instruction (s1_ins_ff),
      .pc          (pc_ff),
      .index_reg   (index_ff),
      .stack_top   (stack_top),
      .vx          (vx_ff),
      .vy          (vy_ff),
      .v0          (v0_ff),
      .result      (exec_result),
      .stack_ctl   (exec_stack_ctl)
   );

   vmies_stack #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock      (clock),
      .reset      (reset),
      .push       (exec_go && exec_stack_ctl.push),
      .pop        (exec_go && exec_stack_ctl.pop),
      .push_value (pc_ff + vmies_pkg::PC_STEP),
      .stack_top  (stack_top)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pc_ff <= vmies_pkg::PC_RESET;
         index_ff <= '0;
         for (int i = 0; i < vmies_pkg::REG_COUNT; i++) begin
            dreg_ff[i] <= '0;
         end
      end else begin
         if (req_bus.ready) begin
            s1_valid_ff <= req_bus.valid;
         end
         if (out_ready) begin
            rsp_valid_ff <= exec_go;
         end
         if (exec_go) begin
            pc_ff <= exec_result.next_pc;
            index_ff <= exec_result.index_value;
         end
         if (fwd_write) begin
            dreg_ff[exec_result.write_index] <= exec_result.write_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_go) begin
         s1_ins_ff <= req_bus.instruction;
         vx_ff <= vx_in;
         vy_ff <= vy_in;
         v0_ff <= v0_in;
      end
      if (exec_go) begin
         rsp_ff <= exec_result;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.next_pc = rsp_ff.next_pc;
   assign rsp_bus.write_valid = rsp_ff.write_valid;
   assign rsp_bus.write_index = rsp_ff.write_index;
   assign rsp_bus.write_value = rsp_ff.write_value;
   assign rsp_bus.index_value = rsp_ff.index_value;
   assign rsp_bus.skipped = rsp_ff.skipped;
   assign rsp_bus.unhandled = rsp_ff.unhandled;

endmodule

`default_nettype wire
